// ===== hdl/assert_macros.svh =====
// assertion helpers for the hash table engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BHTE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BHTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BHTE_ASSERT(lbl, clk, rst_n, prop, msg)
`define BHTE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/bhte_pkg.sv =====
// ----------------------------------------------------------------------------
// bhte_pkg
// shared types and constants of the bucketed hash table engine
// ----------------------------------------------------------------------------
package bhte_pkg;

    localparam int MAX_BUCKETS_DEF      = 256;
    localparam int SLOTS_PER_BUCKET_DEF = 4;
    localparam int KEY_BITS_DEF         = 64;
    localparam int VALUE_BITS_DEF       = 32;

    localparam int CMD_W     = 3;
    localparam int KEY_W     = 64;
    localparam int HASH_W    = 64;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 11;
    localparam int BCOUNT_W  = 9;
    localparam int DIV_CNT_W = 7;

    localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 9'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET     = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_REPLACE = 3'd2,
        CMD_DELETE  = 3'd3,
        CMD_GET     = 3'd4,
        CMD_EXISTS  = 3'd5,
        CMD_CLEAR   = 3'd6,
        CMD_NOP     = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_PRESENT   = 2'd3
    } status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hdl/bhte_mod_unit.sv =====
// ----------------------------------------------------------------------------
// bhte_mod_unit
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module bhte_mod_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [bhte_pkg::HASH_W-1:0]     dividend,
    input  logic [bhte_pkg::BCOUNT_W-1:0]   divisor,
    output logic [bhte_pkg::BCOUNT_W-1:0]   remainder,
    output bhte_pkg::div_stat_t             stat
);

    logic [bhte_pkg::HASH_W-1:0]    dvd_reg;
    logic [bhte_pkg::BCOUNT_W-1:0]  dvs_reg;
    logic [bhte_pkg::BCOUNT_W-1:0]  rem_reg;
    logic [bhte_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [bhte_pkg::BCOUNT_W:0]    trial;
    logic [bhte_pkg::BCOUNT_W-1:0]  rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[bhte_pkg::HASH_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = bhte_pkg::BCOUNT_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = bhte_pkg::BCOUNT_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == bhte_pkg::DIV_CNT_W'(bhte_pkg::HASH_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[bhte_pkg::HASH_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hdl/bucketed_hash_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// bucketed_hash_table_engine_core
// key/value table in fixed buckets of slots, bucket chosen by hash modulo
//
// channel   direction  handshake         payload
// in        request    in_valid/in_stall command, key, key_hash, value
// out       result     out_valid/out_stall status, found, read_value, element_count
// cfg       write      cfg_valid/cfg_ready cfg_data (bucket_count)
//
// lookup commands pass through the bit-serial modulo (a shift per hash bit, then
// a done strobe), then a bucket row read, an evaluate and write, and the output
// load; the next request is taken in the cycle after the output load
// clear sweeps the row memory before the result, one bucket row per cycle
// after reset a sweep over all MAX_BUCKETS rows clears the row memory, in_stall high
// the result sits in an output register; a stalled result holds only the next load
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bucketed_hash_table_engine_core
#(
    parameter int MAX_BUCKETS      = bhte_pkg::MAX_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = bhte_pkg::SLOTS_PER_BUCKET_DEF,
    parameter int KEY_BITS         = bhte_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS       = bhte_pkg::VALUE_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bhte_pkg::CMD_W-1:0]      command,
    input  logic [bhte_pkg::KEY_W-1:0]      key,
    input  logic [bhte_pkg::HASH_W-1:0]     key_hash,
    input  logic [bhte_pkg::VALUE_W-1:0]    value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bhte_pkg::STATUS_W-1:0]   status,
    output logic                            found,
    output logic [bhte_pkg::VALUE_W-1:0]    read_value,
    output logic [bhte_pkg::COUNT_W-1:0]    element_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bhte_pkg::BCOUNT_W-1:0]   cfg_data
);

    localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int TOTAL = MAX_BUCKETS * SLOTS_PER_BUCKET;
    localparam int CW    = $clog2(TOTAL + 1);

    typedef enum logic [6:0] {
        S_INIT = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_EVAL = 7'b0010000,
        S_CLR  = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [SLOTS_PER_BUCKET-1:0]                     mem_v   [MAX_BUCKETS];
    logic [SLOTS_PER_BUCKET-1:0][bhte_pkg::HASH_W-1:0] mem_h [MAX_BUCKETS];
    logic [SLOTS_PER_BUCKET-1:0][KEY_BITS-1:0]       mem_k   [MAX_BUCKETS];
    logic [SLOTS_PER_BUCKET-1:0][VALUE_BITS-1:0]     mem_d   [MAX_BUCKETS];

    logic [SLOTS_PER_BUCKET-1:0]                     rd_v_reg;
    logic [SLOTS_PER_BUCKET-1:0][bhte_pkg::HASH_W-1:0] rd_h_reg;
    logic [SLOTS_PER_BUCKET-1:0][KEY_BITS-1:0]       rd_k_reg;
    logic [SLOTS_PER_BUCKET-1:0][VALUE_BITS-1:0]     rd_d_reg;

    logic [SLOTS_PER_BUCKET-1:0]                     wr_v;
    logic [SLOTS_PER_BUCKET-1:0][bhte_pkg::HASH_W-1:0] wr_h;
    logic [SLOTS_PER_BUCKET-1:0][KEY_BITS-1:0]       wr_k;
    logic [SLOTS_PER_BUCKET-1:0][VALUE_BITS-1:0]     wr_d;

    logic [bhte_pkg::BCOUNT_W-1:0] bcount_reg;
    logic [bhte_pkg::BCOUNT_W-1:0] bcount_eff;
    bhte_pkg::cmd_t                cmd_reg;
    logic [KEY_BITS-1:0]           key_reg;
    logic [bhte_pkg::HASH_W-1:0]   hash_reg;
    logic [VALUE_BITS-1:0]         val_reg;
    logic [BW-1:0]                 bucket_reg;
    logic [BW-1:0]                 sweep_reg;
    logic [BW-1:0]                 addr;
    logic [CW-1:0]                 count_reg;

    bhte_pkg::status_t             res_status_reg;
    logic                          res_found_reg;
    logic [VALUE_BITS-1:0]         res_value_reg;
    logic                          out_valid_reg;
    bhte_pkg::status_t             status_reg;
    logic                          found_reg;
    logic [bhte_pkg::VALUE_W-1:0]  read_value_reg;
    logic [bhte_pkg::COUNT_W-1:0]  count_out_reg;

    logic                          accept;
    logic                          div_start;
    logic [bhte_pkg::BCOUNT_W-1:0] div_rem;
    bhte_pkg::div_stat_t           div_stat;

    logic                          hit;
    logic                          has_free;
    logic [SW-1:0]                 hit_idx;
    logic [SW-1:0]                 free_idx;
    logic                          mem_we;
    logic                          inc_cnt;
    logic                          dec_cnt;
    bhte_pkg::status_t             ev_status;
    logic [VALUE_BITS-1:0]         ev_value;
    logic                          out_free;
    logic                          sweep_last;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || !out_stall;
    assign sweep_last = (sweep_reg == BW'(MAX_BUCKETS - 1));
    assign div_start  = accept && (command <= bhte_pkg::CMD_W'(bhte_pkg::CMD_EXISTS));

    always_comb
    begin
        if (bcount_reg == '0)
        begin
            bcount_eff = bhte_pkg::BCOUNT_W'(1);
        end
        else if (32'(bcount_reg) > 32'(MAX_BUCKETS))
        begin
            bcount_eff = bhte_pkg::BCOUNT_W'(MAX_BUCKETS);
        end
        else
        begin
            bcount_eff = bcount_reg;
        end
    end

    bhte_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (key_hash),
        .divisor   (bcount_eff),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    // slot search and row update
    always_comb
    begin
        hit      = 1'b0;
        has_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < SLOTS_PER_BUCKET; i++)
        begin
            if (rd_v_reg[i])
            begin
                if (!hit && rd_h_reg[i] == hash_reg && rd_k_reg[i] == key_reg)
                begin
                    hit     = 1'b1;
                    hit_idx = SW'(i);
                end
            end
            else if (!has_free)
            begin
                has_free = 1'b1;
                free_idx = SW'(i);
            end
        end

        wr_v      = rd_v_reg;
        wr_h      = rd_h_reg;
        wr_k      = rd_k_reg;
        wr_d      = rd_d_reg;
        mem_we    = 1'b0;
        inc_cnt   = 1'b0;
        dec_cnt   = 1'b0;
        ev_status = bhte_pkg::ST_OK;
        ev_value  = '0;

        case (cmd_reg)
            bhte_pkg::CMD_SET, bhte_pkg::CMD_ADD:
            begin
                if (hit)
                begin
                    if (cmd_reg == bhte_pkg::CMD_SET)
                    begin
                        wr_d[hit_idx] = val_reg;
                        mem_we        = 1'b1;
                    end
                    else
                    begin
                        ev_status = bhte_pkg::ST_PRESENT;
                    end
                end
                else if (has_free)
                begin
                    wr_v[free_idx] = 1'b1;
                    wr_h[free_idx] = hash_reg;
                    wr_k[free_idx] = key_reg;
                    wr_d[free_idx] = val_reg;
                    mem_we         = 1'b1;
                    inc_cnt        = 1'b1;
                end
                else
                begin
                    ev_status = bhte_pkg::ST_FULL;
                end
            end
            bhte_pkg::CMD_REPLACE:
            begin
                if (hit)
                begin
                    wr_d[hit_idx] = val_reg;
                    mem_we        = 1'b1;
                end
                else
                begin
                    ev_status = bhte_pkg::ST_NOT_FOUND;
                end
            end
            bhte_pkg::CMD_DELETE:
            begin
                if (hit)
                begin
                    wr_v[hit_idx] = 1'b0;
                    mem_we        = 1'b1;
                    dec_cnt       = (count_reg != '0);
                end
                else
                begin
                    ev_status = bhte_pkg::ST_NOT_FOUND;
                end
            end
            bhte_pkg::CMD_GET:
            begin
                if (hit)
                begin
                    ev_value = rd_d_reg[hit_idx];
                end
                else
                begin
                    ev_status = bhte_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                if (!hit)
                begin
                    ev_status = bhte_pkg::ST_NOT_FOUND;
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == bhte_pkg::CMD_CLEAR)
                    begin
                        state_next = S_CLR;
                    end
                    else if (command == bhte_pkg::CMD_NOP)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_FIN;
            end
            S_CLR:
            begin
                if (sweep_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            count_reg     <= '0;
            bcount_reg    <= bhte_pkg::BCOUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                bcount_reg <= cfg_data;
            end
            if (state_reg == S_INIT || state_reg == S_CLR)
            begin
                sweep_reg <= sweep_last ? '0 : sweep_reg + 1'b1;
            end
            if (accept && command == bhte_pkg::CMD_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (state_reg == S_EVAL)
            begin
                if (inc_cnt)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else if (dec_cnt)
                begin
                    count_reg <= count_reg - 1'b1;
                end
            end
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg        <= bhte_pkg::cmd_t'(command);
            key_reg        <= KEY_BITS'(key);
            hash_reg       <= key_hash;
            val_reg        <= VALUE_BITS'(value);
            res_status_reg <= bhte_pkg::ST_OK;
            res_found_reg  <= 1'b0;
            res_value_reg  <= '0;
        end
        if (div_stat.done)
        begin
            bucket_reg <= BW'(div_rem);
        end
        if (state_reg == S_EVAL)
        begin
            res_status_reg <= ev_status;
            res_found_reg  <= hit;
            res_value_reg  <= ev_value;
        end
        if (state_reg == S_FIN && out_free)
        begin
            status_reg     <= res_status_reg;
            found_reg      <= res_found_reg;
            read_value_reg <= bhte_pkg::VALUE_W'(res_value_reg);
            count_out_reg  <= bhte_pkg::COUNT_W'(count_reg);
        end
    end

    assign addr = (state_reg == S_INIT || state_reg == S_CLR) ? sweep_reg : bucket_reg;

    // bucket row memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INIT || state_reg == S_CLR)
        begin
            mem_v[addr] <= '0;
        end
        else if (state_reg == S_EVAL && mem_we)
        begin
            mem_v[addr] <= wr_v;
            mem_h[addr] <= wr_h;
            mem_k[addr] <= wr_k;
            mem_d[addr] <= wr_d;
        end
        rd_v_reg <= mem_v[addr];
        rd_h_reg <= mem_h[addr];
        rd_k_reg <= mem_k[addr];
        rd_d_reg <= mem_d[addr];
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found         = found_reg;
    assign read_value    = read_value_reg;
    assign element_count = count_out_reg;

    `BHTE_ASSERT(a_div_done_in_div, clk, rst_n, div_stat.done |-> (state_reg == S_DIV), "modulo result outside divide state")
    `BHTE_ASSERT(a_out_from_fin, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_FIN), "result loaded outside finish state")
    `BHTE_ASSERT(a_count_bound, clk, rst_n, 32'(count_reg) <= TOTAL, "element count above slot total")
    `BHTE_ASSERT(a_accept_leaves_idle, clk, rst_n, accept |=> (state_reg != S_IDLE), "request accepted but engine still idle")

endmodule

// ===== bench/bucketed_hash_table_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// bucketed_hash_table_engine_core_tb
// self-checking bench: a shadow table predicts every result, random and
// directed requests under several bucket counts and idle patterns
// ----------------------------------------------------------------------------
module bucketed_hash_table_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = bhte_pkg::MAX_BUCKETS_DEF;
    localparam int NS = bhte_pkg::SLOTS_PER_BUCKET_DEF;

    typedef struct packed {
        logic [bhte_pkg::STATUS_W-1:0] st;
        logic                          fnd;
        logic [bhte_pkg::VALUE_W-1:0]  rd;
        logic [bhte_pkg::COUNT_W-1:0]  cnt;
    } table_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [bhte_pkg::CMD_W-1:0] command = '0;
    logic [bhte_pkg::KEY_W-1:0] key = '0;
    logic [bhte_pkg::HASH_W-1:0] key_hash = '0;
    logic [bhte_pkg::VALUE_W-1:0] value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [bhte_pkg::STATUS_W-1:0] status;
    logic found;
    logic [bhte_pkg::VALUE_W-1:0] read_value;
    logic [bhte_pkg::COUNT_W-1:0] element_count;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [bhte_pkg::BCOUNT_W-1:0] cfg_data = '0;

    bucketed_hash_table_engine_core dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [bhte_pkg::BCOUNT_W-1:0] shadow_bcount;
    logic                          shadow_valid [NB*NS];
    logic [bhte_pkg::HASH_W-1:0]   shadow_hash [NB*NS];
    logic [bhte_pkg::KEY_W-1:0]    shadow_key [NB*NS];
    logic [bhte_pkg::VALUE_W-1:0]  shadow_value [NB*NS];
    logic [bhte_pkg::COUNT_W-1:0]  shadow_total;
    table_reply_t pending_replies [$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int hold_cycles = 0;
    logic [bhte_pkg::KEY_W-1:0]  key_pool [16];
    logic [bhte_pkg::HASH_W-1:0] hash_pool [16];

    function automatic table_reply_t apply_request(bhte_pkg::cmd_t c,
                                                   logic [bhte_pkg::KEY_W-1:0] k,
                                                   logic [bhte_pkg::HASH_W-1:0] h,
                                                   logic [bhte_pkg::VALUE_W-1:0] v);
        table_reply_t r;
        int nb;
        int base;
        int hit;
        int fr;
        r = '0;
        nb = (shadow_bcount == 0) ? 1 : (shadow_bcount > NB) ? NB : shadow_bcount;
        base = int'(h % 64'(nb)) * NS;
        hit = -1;
        fr = -1;
        if (c == bhte_pkg::CMD_CLEAR)
        begin
            foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
            shadow_total = '0;
        end
        else if (c != bhte_pkg::CMD_NOP)
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (shadow_valid[base+i])
                begin
                    if (hit < 0 && shadow_hash[base+i] == h && shadow_key[base+i] == k)
                        hit = i;
                end
                else if (fr < 0)
                    fr = i;
            end
            r.fnd = (hit >= 0);
            case (c)
                bhte_pkg::CMD_SET, bhte_pkg::CMD_ADD:
                    if (hit >= 0)
                    begin
                        if (c == bhte_pkg::CMD_SET) shadow_value[base+hit] = v;
                        else r.st = bhte_pkg::ST_PRESENT;
                    end
                    else if (fr >= 0)
                    begin
                        shadow_valid[base+fr] = 1'b1;
                        shadow_hash[base+fr] = h;
                        shadow_key[base+fr] = k;
                        shadow_value[base+fr] = v;
                        shadow_total++;
                    end
                    else
                        r.st = bhte_pkg::ST_FULL;
                bhte_pkg::CMD_REPLACE:
                    if (hit >= 0) shadow_value[base+hit] = v;
                    else r.st = bhte_pkg::ST_NOT_FOUND;
                bhte_pkg::CMD_DELETE:
                    if (hit >= 0)
                    begin
                        shadow_valid[base+hit] = 1'b0;
                        if (shadow_total > 0) shadow_total--;
                    end
                    else
                        r.st = bhte_pkg::ST_NOT_FOUND;
                bhte_pkg::CMD_GET:
                    if (hit >= 0) r.rd = shadow_value[base+hit];
                    else r.st = bhte_pkg::ST_NOT_FOUND;
                default:
                    if (hit < 0) r.st = bhte_pkg::ST_NOT_FOUND;
            endcase
        end
        r.cnt = shadow_total;
        return r;
    endfunction

    task automatic send_request(bhte_pkg::cmd_t c, logic [bhte_pkg::KEY_W-1:0] k,
                                logic [bhte_pkg::HASH_W-1:0] h,
                                logic [bhte_pkg::VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        key <= k;
        key_hash <= h;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_replies.push_back(apply_request(c, k, h, v));
    endtask

    task automatic drain_and_write_bcount(logic [bhte_pkg::BCOUNT_W-1:0] bc);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= bc;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        shadow_bcount = bc;
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle);
        if (out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t unexpected result status=%0d", $realtime, status);
                errors++;
            end
            else
            begin
                table_reply_t e;
                e = pending_replies.pop_front();
                if (e != {status, found, read_value, element_count})
                begin
                    $display("%0t mismatch expected st=%0d f=%0d rd=%h cnt=%0d", $realtime,
                             e.st, e.fnd, e.rd, e.cnt);
                    $display("%0t          actual   st=%0d f=%0d rd=%h cnt=%0d", $realtime,
                             status, found, read_value, element_count);
                    errors++;
                end
            end
        end
    end

    function automatic bhte_pkg::cmd_t pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 30) return bhte_pkg::CMD_SET;
        if (r < 42) return bhte_pkg::CMD_ADD;
        if (r < 54) return bhte_pkg::CMD_REPLACE;
        if (r < 66) return bhte_pkg::CMD_DELETE;
        if (r < 84) return bhte_pkg::CMD_GET;
        if (r < 96) return bhte_pkg::CMD_EXISTS;
        if (r < 98) return bhte_pkg::CMD_NOP;
        return bhte_pkg::CMD_CLEAR;
    endfunction

    task automatic test_directed();
        logic [63:0] ones;
        ones = '1;
        send_request(bhte_pkg::CMD_GET, 64'd0, 64'd0, 32'd0);
        send_request(bhte_pkg::CMD_SET, 64'd0, 64'd0, 32'd0);
        send_request(bhte_pkg::CMD_GET, 64'd0, 64'd0, 32'd5);
        send_request(bhte_pkg::CMD_SET, ones, ones, '1);
        send_request(bhte_pkg::CMD_SET, ones, ones, 32'h1234);
        send_request(bhte_pkg::CMD_ADD, ones, ones, 32'd7);
        send_request(bhte_pkg::CMD_GET, ones, ones, 32'd0);
        send_request(bhte_pkg::CMD_EXISTS, ones, ones, 32'd0);
        send_request(bhte_pkg::CMD_REPLACE, ones, ones, '1);
        send_request(bhte_pkg::CMD_REPLACE, 64'd9, ones, 32'd1);
        send_request(bhte_pkg::CMD_EXISTS, 64'd9, ones, 32'd0);
        for (int i = 0; i < 5; i++)
            send_request(bhte_pkg::CMD_ADD, 64'(i + 100), 64'd3, 32'(i));
        send_request(bhte_pkg::CMD_SET, 64'd200, 64'd3, 32'd1);
        send_request(bhte_pkg::CMD_DELETE, 64'd101, 64'd3, 32'd0);
        send_request(bhte_pkg::CMD_DELETE, 64'd101, 64'd3, 32'd0);
        send_request(bhte_pkg::CMD_ADD, 64'd104, 64'd3, 32'd9);
        send_request(bhte_pkg::CMD_NOP, ones, ones, '1);
        send_request(bhte_pkg::CMD_CLEAR, 64'd0, 64'd0, 32'd0);
        send_request(bhte_pkg::CMD_GET, ones, ones, 32'd0);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            int p;
            p = $urandom_range(15);
            if ($urandom_range(9) == 0)
                send_request(pick_cmd(), {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
            else
                send_request(pick_cmd(), key_pool[p], hash_pool[p], $urandom);
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 2000;
        test_random(8);
    endtask

    task automatic test_bucket_counts();
        drain_and_write_bcount(9'd1);
        test_random(150);
        drain_and_write_bcount(9'd0);
        test_random(60);
        drain_and_write_bcount(9'd511);
        test_random(60);
        drain_and_write_bcount(9'd3);
        test_random(150);
        drain_and_write_bcount(9'd256);
        test_random(150);
        drain_and_write_bcount(9'd255);
        test_random(150);
    endtask

    initial
    begin
        shadow_bcount = bhte_pkg::BCOUNT_RESET;
        shadow_total = '0;
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
        foreach (key_pool[i])
        begin
            key_pool[i] = {$urandom, $urandom};
            hash_pool[i] = (i < 8) ? 64'($urandom_range(7)) : {$urandom, $urandom};
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        send_idle = 9;
        recv_idle = 76;
        test_directed();
        test_random(150);
        send_idle = 76;
        recv_idle = 9;
        test_backpressure();
        test_bucket_counts();
        send_idle = 0;
        recv_idle = 0;
        test_random(150);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("** bucketed_hash_table_engine_core: PASSED **");
        else
            $display("** bucketed_hash_table_engine_core: FAILED **");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("** bucketed_hash_table_engine_core: FAILED **");
        $finish;
    end
endmodule

// ===== bucketed_hash_table_engine_core.f =====
+incdir+hdl
hdl/bhte_pkg.sv
hdl/bhte_mod_unit.sv
hdl/bucketed_hash_table_engine_core.sv
bench/bucketed_hash_table_engine_core_tb.sv
